/* design/lhsp_pkg.sv */
// lhsp_pkg: shared types and constants for the lift height speed profiler
// no dependencies; used by lhsp_ctrl, lhsp_datapath and the top level
package lhsp_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int SW          = HEIGHT_BITS + 2;
  localparam int CFG_BITS    = 15;
  localparam int IDX_BITS    = 2;

  // floor(x/5) = (x * 52429) >> 18, exact for x below 2**18
  localparam int DIV5_MUL_BITS = 16;
  localparam logic [DIV5_MUL_BITS-1:0] DIV5_MUL = 16'd52429;
  localparam int DIV5_SHIFT    = 18;
  localparam int PROD_BITS     = HEIGHT_BITS + DIV5_MUL_BITS;

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic signed [SW-1:0]   sw_t;
  typedef logic [CFG_BITS-1:0]    cfg_t;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_DEAD_ZONE_MAX  = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_DEAD_ZONE_MIN  = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_EARLY_DECEL    = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_MAX_SLOW       = 2'd3;

  localparam cfg_t DEAD_ZONE_MAX_RST = 15'd10;
  localparam cfg_t DEAD_ZONE_MIN_RST = 15'd2;
  localparam cfg_t EARLY_DECEL_RST   = 15'd5;
  localparam cfg_t MAX_SLOW_RST      = 15'd50;

  // item kinds
  localparam logic OP_PLAN = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // button codes
  localparam logic [1:0] BTN_STOP  = 2'd0;
  localparam logic [1:0] BTN_RAISE = 2'd1;
  localparam logic [1:0] BTN_LOWER = 2'd2;

  // run status codes
  localparam logic [1:0] RUN_DONE  = 2'd0;
  localparam logic [1:0] RUN_STEADY = 2'd1;
  localparam logic [1:0] RUN_RAMP  = 2'd2;
  localparam logic [1:0] RUN_OVER  = 2'd3;

  localparam logic [2:0] GEAR_NONE = 3'd0;
  localparam logic [2:0] GEAR_MIN  = 3'd1;
  localparam logic [2:0] GEAR_MAX  = 3'd6;

  typedef struct packed {
    logic        op;
    logic [14:0] path_target;
    logic        target_valid;
    logic [14:0] actual_height;
    logic        side_above_mode;
    logic        next_is_accurate_pos;
    logic        first_in_path;
    logic        in_lift_mode;
    logic        pause;
  } item_t;

  typedef struct packed {
    logic       arm_lift;
    logic       request_lift_mode;
    logic [2:0] speed_gear;
    logic [1:0] button;
    logic [1:0] run_status;
    logic       done_res;
  } result_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic ratio;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic lift_mode;
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

/* design/lhsp_ctrl.sv */
// lhsp_ctrl: sequencer for one item at a time through the datapath
// depends on lhsp_pkg (cmd_t, status_t)
module lhsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lhsp_pkg::status_t st,
  output lhsp_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_RATIO = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (st.is_tick && st.lift_mode) begin
          state_next = S_RATIO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RATIO: begin
        cmd.ratio = 1'b1;
        state_next = st.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/lhsp_datapath.sv */
// lhsp_datapath: config registers, move state, gear arithmetic, 3-step divider, output word
// depends on lhsp_pkg
module lhsp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lhsp_pkg::IDX_BITS-1:0] wr_index,
  input  lhsp_pkg::cfg_t                wr_data,
  input  lhsp_pkg::item_t               item,
  input  lhsp_pkg::cmd_t                cmd,
  output lhsp_pkg::status_t             st,
  output lhsp_pkg::result_t             result,
  output logic                          result_valid,
  input  logic                          result_stall
);

  lhsp_pkg::cfg_t dz_max;
  lhsp_pkg::cfg_t dz_min;
  lhsp_pkg::cfg_t early_decel;
  lhsp_pkg::cfg_t max_slow;

  lhsp_pkg::item_t   it;
  lhsp_pkg::height_t target_height;
  lhsp_pkg::height_t move_length;
  lhsp_pkg::height_t start_height;

  logic [lhsp_pkg::PROD_BITS-1:0] prod;
  lhsp_pkg::height_t done_len;
  lhsp_pkg::sw_t     adj;
  lhsp_pkg::result_t res;
  lhsp_pkg::result_t res_prep;
  lhsp_pkg::result_t out_r;
  logic              out_valid;

  logic [lhsp_pkg::SW-1:0] rem;
  logic [14:0]             dvsr;
  logic [1:0]              quot;
  logic [1:0]              div_cnt;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_max      <= lhsp_pkg::DEAD_ZONE_MAX_RST;
      dz_min      <= lhsp_pkg::DEAD_ZONE_MIN_RST;
      early_decel <= lhsp_pkg::EARLY_DECEL_RST;
      max_slow    <= lhsp_pkg::MAX_SLOW_RST;
    end else if (wr_en) begin
      case (wr_index)
        lhsp_pkg::REG_DEAD_ZONE_MAX: dz_max      <= wr_data;
        lhsp_pkg::REG_DEAD_ZONE_MIN: dz_min      <= wr_data;
        lhsp_pkg::REG_EARLY_DECEL:   early_decel <= wr_data;
        lhsp_pkg::REG_MAX_SLOW:      max_slow    <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // plan arithmetic
  logic [14:0] plan_diff;
  logic        plan_skip;
  logic        plan_arm;
  logic [14:0] tick_dl;

  assign plan_diff = (it.path_target > it.actual_height) ?
                     (it.path_target - it.actual_height) : (it.actual_height - it.path_target);
  assign plan_skip = it.side_above_mode && it.next_is_accurate_pos && !it.first_in_path;
  assign plan_arm  = it.target_valid && (plan_diff > dz_max);

  lhsp_pkg::height_t act_h;
  assign act_h   = lhsp_pkg::height_t'(it.actual_height);

  lhsp_pkg::height_t dl_full;
  assign dl_full = (start_height > act_h) ? (start_height - act_h) : (act_h - start_height);
  assign tick_dl = dl_full[14:0];

  // first fields of the result word, known right after the item is loaded
  always_comb begin
    res_prep = '0;
    if (it.op == lhsp_pkg::OP_PLAN) begin
      res_prep.arm_lift = !plan_skip && plan_arm;
    end else if (!it.in_lift_mode) begin
      res_prep.request_lift_mode = 1'b1;
    end
  end

  // ratio stage
  lhsp_pkg::height_t q5;
  lhsp_pkg::height_t r_full;
  logic [2:0]        r5;
  lhsp_pkg::sw_t     len_s, dl_s, ed_s, sd_s, q_s, f4, p2, p8, half_s, num;
  lhsp_pkg::sw_t     dzmin_s;
  logic [2:0]        gear_c;
  logic [1:0]        status_c;
  logic [1:0]        button_c;
  logic              done_c;
  logic              need_div;

  always_comb begin
    q5      = lhsp_pkg::height_t'(prod >> lhsp_pkg::DIV5_SHIFT);
    r_full  = move_length - (q5 << 2) - q5;
    r5      = r_full[2:0];
    len_s   = lhsp_pkg::sw_t'(move_length);
    dl_s    = lhsp_pkg::sw_t'(done_len);
    ed_s    = lhsp_pkg::sw_t'(early_decel);
    sd_s    = lhsp_pkg::sw_t'(max_slow);
    q_s     = lhsp_pkg::sw_t'(q5);
    half_s  = lhsp_pkg::sw_t'(move_length >> 1);
    dzmin_s = lhsp_pkg::sw_t'(dz_min);
    // floor(4*len/5) from floor(len/5) and the remainder
    f4      = (q_s <<< 2) + ((r5 == 3'd0) ? lhsp_pkg::sw_t'(0) : lhsp_pkg::sw_t'(r5 - 3'd1));
    if (q_s > sd_s) begin
      p2 = sd_s;
      p8 = len_s - sd_s - ed_s;
    end else begin
      p2 = q_s;
      p8 = f4 - ed_s;
    end
    num      = len_s - dl_s - ed_s;
    need_div = 1'b0;
    if (half_s <= ed_s) begin
      gear_c = lhsp_pkg::GEAR_MIN;
      status_c = lhsp_pkg::RUN_STEADY;
    end else if (dl_s <= p8) begin
      gear_c = lhsp_pkg::GEAR_MAX;
      status_c = lhsp_pkg::RUN_STEADY;
    end else if (dl_s < len_s) begin
      status_c = lhsp_pkg::RUN_RAMP;
      if (p2 <= 0 || num <= 0) begin
        gear_c = lhsp_pkg::GEAR_MIN;
      end else if (num >= p2) begin
        gear_c = lhsp_pkg::GEAR_MAX;
      end else begin
        gear_c   = lhsp_pkg::GEAR_MIN;
        need_div = 1'b1;
      end
    end else begin
      gear_c = lhsp_pkg::GEAR_MIN;
      status_c = lhsp_pkg::RUN_OVER;
    end
    done_c = 1'b0;
    if (adj < -dzmin_s) begin
      button_c = lhsp_pkg::BTN_LOWER;
    end else if (adj > dzmin_s) begin
      button_c = lhsp_pkg::BTN_RAISE;
    end else begin
      button_c = lhsp_pkg::BTN_STOP;
      status_c = lhsp_pkg::RUN_DONE;
      done_c   = 1'b1;
    end
    if (it.pause) begin
      button_c = lhsp_pkg::BTN_STOP;
    end
  end

  // divider step: 5*num / p2 with quotient below 5, three bits
  logic [lhsp_pkg::SW-1:0] trial;
  logic                    qbit;
  assign trial = {3'b000, dvsr} << div_cnt;
  assign qbit  = (rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_height <= '0;
      move_length   <= '0;
      start_height  <= '0;
    end else if (cmd.prep && it.op == lhsp_pkg::OP_PLAN && !plan_skip) begin
      if (plan_arm) begin
        target_height <= lhsp_pkg::height_t'(it.path_target);
        move_length   <= lhsp_pkg::height_t'(plan_diff);
        start_height  <= act_h;
      end else begin
        target_height <= act_h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      it <= item;
    end
    if (cmd.prep) begin
      prod     <= move_length * lhsp_pkg::DIV5_MUL;
      done_len <= lhsp_pkg::height_t'(tick_dl);
      adj      <= lhsp_pkg::sw_t'(target_height) - lhsp_pkg::sw_t'(act_h);
      res      <= res_prep;
    end
    if (cmd.ratio) begin
      res.speed_gear <= gear_c;
      res.button     <= button_c;
      res.run_status <= status_c;
      res.done_res   <= done_c;
      rem            <= lhsp_pkg::SW'((num <<< 2) + num);
      dvsr           <= p2[14:0];
      quot           <= '0;
      div_cnt        <= 2'd2;
    end
    if (cmd.div_step) begin
      if (qbit) begin
        rem <= rem - trial;
      end
      quot    <= {quot[0], qbit};
      div_cnt <= div_cnt - 2'd1;
      if (div_cnt == 2'd0) begin
        res.speed_gear <= {quot, qbit} + 3'd1;
      end
    end
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign result       = out_r;
  assign result_valid = out_valid;

  assign st.is_tick   = (it.op == lhsp_pkg::OP_TICK);
  assign st.lift_mode = it.in_lift_mode;
  assign st.need_div  = need_div;
  assign st.div_last  = (div_cnt == 2'd0);
  assign st.out_free  = !out_valid || !result_stall;

endmodule

/* design/lift_height_speed_profiler.sv */
// lift_height_speed_profiler: top level, joins the sequencer and the datapath
// depends on lhsp_pkg, lhsp_ctrl, lhsp_datapath
//
// Takes one item at a time. A plan word, or a tick while the chassis is not in
// lift mode, goes through the prepare and done states; a tick that computes a gear
// also goes through the ratio state, and the divide state when the ramp gear needs
// 5*num/den, which a three-step restoring divider in the datapath works out one
// quotient bit per cycle. The next word is accepted in the cycle after the result
// is loaded into the output register, even if that result is still stalled.
// Configuration writes go straight into the registers and are taken at any time.
module lift_height_speed_profiler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lhsp_pkg::IDX_BITS-1:0] wr_index,
  input  lhsp_pkg::cfg_t                wr_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  lhsp_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output lhsp_pkg::result_t             result
);

  lhsp_pkg::cmd_t    cmd;
  lhsp_pkg::status_t st;

  lhsp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  lhsp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
